// File: src/smm_pkg.sv
// ============================================================================
// smm_pkg: shared types and constants of the sparse modular matrix product
// Field widths, list depth, the modulus and the stored entry layout.
// ============================================================================
package smm_pkg;

	localparam int NNZ    = 1024;
	localparam int IDX_W  = $clog2(NNZ);
	localparam int CNT_W  = IDX_W + 1;
	localparam int DIM_W  = 10;
	localparam int VAL_W  = 30;
	localparam int PROD_W = 2 * VAL_W;

	localparam logic [VAL_W:0]   PRIME    = (VAL_W + 1)'(1000000007);
	localparam logic [VAL_W+1:0] PRIME_X2 = (VAL_W + 2)'(2000000014);

	// Barrett constant: floor(2^60 / modulus), which fits in 31 bits.
	localparam logic [VAL_W:0]   BAR_M    =
		(VAL_W + 1)'((64'd1 << PROD_W) / 64'd1000000007);

	typedef enum logic [1:0] {
		ACT_LOAD_A = 2'd0,
		ACT_LOAD_B = 2'd1,
		ACT_NEXT   = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_ORDER = 2'd2
	} status_t;

	typedef struct packed {
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		logic [VAL_W-1:0] val;
	} entry_t;

endpackage

// File: src/sparse_matrix_multiply_modular_top.sv
// ============================================================================
// sparse_matrix_multiply_modular_top: sparse matrix product modulo a prime
// Coordinate lists for A and B in two memories, walked by a merge sequencer.
// ============================================================================
// Usage. A word is presented on action and the entry ports and is taken at a
// clock edge where start is high and busy is low. Each taken word produces
// exactly one result word, shown for one cycle with done high; the receiver
// must take it then, since the block cannot be held off.
// For loads of A (row-major) and B (column-major), clear, and a next request
// after the walk has finished, the result word appears in the cycle after the
// word was taken and busy stays low, so they may be issued every cycle. Any
// other next request holds busy high while the sequencer walks the lists. Each
// memory read is issued in one state and its data evaluated in the next. A
// merge step over unequal indices advances the list with the smaller index; a
// matching index pair is multiplied, and the 60-bit product is reduced by a
// Barrett reduction (quotient estimate, remainder, final correction) before it
// is accumulated. Skipping a row whose B walk is done steps through every A
// entry of that row.
// Reset clears both counts, the cursor and the finished flag; the entry
// memories keep whatever they hold, as only entries below the counts are
// ever read. No clearing pass is needed after reset.
// ============================================================================
module sparse_matrix_multiply_modular_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   action,
	input  logic [smm_pkg::DIM_W-1:0]    entry_row,
	input  logic [smm_pkg::DIM_W-1:0]    entry_col,
	input  logic [smm_pkg::VAL_W-1:0]    entry_value,
	output logic                         done,
	output logic [smm_pkg::DIM_W-1:0]    result_row,
	output logic [smm_pkg::DIM_W-1:0]    result_col,
	output logic [smm_pkg::VAL_W-1:0]    result_value,
	output logic                         found,
	output logic                         finished,
	output logic [1:0]                   status
);
	import smm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PAIR, S_SKIP0, S_SKIPRD, S_SKIPEV, S_HEAD, S_CMP, S_QUO,
		S_REM, S_FIX, S_ACC, S_FETCH, S_CHK, S_BRD, S_BEV, S_END
	} state_t;

	state_t state_q;

	// Entry memories, one row per stored entry, registered read data.
	entry_t a_mem [NNZ];
	entry_t b_mem [NNZ];
	entry_t a_rd_q, b_rd_q;
	logic              a_re, b_re, a_we, b_we;
	logic [IDX_W-1:0]  a_ra, b_ra;
	entry_t            wr_entry;

	logic [CNT_W-1:0]  a_cnt_q, b_cnt_q, rgs_q, cgs_q, i_q, j_q;
	logic              exh_q, fa_q, fb_q;
	logic [DIM_W-1:0]  a_last_row_q, a_last_col_q, b_last_row_q, b_last_col_q;
	logic [DIM_W-1:0]  row0_q, col0_q;
	logic [VAL_W-1:0]  sum_q, r_q;
	logic [PROD_W-1:0] prod_q;
	logic [VAL_W:0]    quo_q;
	logic [VAL_W+1:0]  rem_q;

	logic [2*VAL_W+1:0] quo_full, qp_full;
	logic [VAL_W+1:0]   rem_t, fix_n;
	logic [VAL_W:0]     acc_t, acc_n;
	logic               a_full, b_full, a_order_ok, b_order_ok, a_ok, b_ok;
	action_t            act;

	assign act = action_t'(action);
	assign busy = (state_q != S_IDLE);
	assign wr_entry = '{row: entry_row, col: entry_col, val: entry_value};

	assign a_full = (a_cnt_q >= CNT_W'(NNZ));
	assign b_full = (b_cnt_q >= CNT_W'(NNZ));
	assign a_order_ok = (a_cnt_q == '0) || (entry_row > a_last_row_q) ||
		((entry_row == a_last_row_q) && (entry_col > a_last_col_q));
	assign b_order_ok = (b_cnt_q == '0) || (entry_col > b_last_col_q) ||
		((entry_col == b_last_col_q) && (entry_row > b_last_row_q));

	assign a_we = (state_q == S_IDLE) && start && (act == ACT_LOAD_A) && !a_full && a_order_ok;
	assign b_we = (state_q == S_IDLE) && start && (act == ACT_LOAD_B) && !b_full && b_order_ok;

	assign a_ok = (i_q < a_cnt_q) && (a_rd_q.row == row0_q);
	assign b_ok = (j_q < b_cnt_q) && (b_rd_q.col == col0_q);

	// Barrett reduction of the product: quotient estimate, remainder below
	// three times the modulus, then the final correction.
	assign quo_full = prod_q[PROD_W-1:VAL_W-1] * BAR_M;
	assign qp_full  = quo_q * PRIME;
	assign rem_t    = prod_q[VAL_W+1:0] - qp_full[VAL_W+1:0];
	assign fix_n    = (rem_q >= PRIME_X2) ? rem_q - PRIME_X2 :
		(rem_q >= {1'b0, PRIME}) ? rem_q - {1'b0, PRIME} : rem_q;

	// The modular accumulate.
	assign acc_t = {1'b0, sum_q} + {1'b0, r_q};
	assign acc_n = (acc_t >= PRIME) ? acc_t - PRIME : acc_t;

	always_comb begin
		a_re = 1'b0;
		b_re = 1'b0;
		a_ra = i_q[IDX_W-1:0];
		b_ra = j_q[IDX_W-1:0];
		case (state_q)
			S_PAIR: begin
				a_ra = rgs_q[IDX_W-1:0];
				b_ra = cgs_q[IDX_W-1:0];
				a_re = (rgs_q < a_cnt_q);
				b_re = (cgs_q < b_cnt_q);
			end
			S_SKIPRD: a_re = (i_q < a_cnt_q);
			S_FETCH: begin
				a_re = fa_q && (i_q < a_cnt_q);
				b_re = fb_q && (j_q < b_cnt_q);
			end
			S_BRD: b_re = (j_q < b_cnt_q);
			default: begin
				a_re = 1'b0;
				b_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[a_cnt_q[IDX_W-1:0]] <= wr_entry;
		end
		if (a_re) begin
			a_rd_q <= a_mem[a_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[b_cnt_q[IDX_W-1:0]] <= wr_entry;
		end
		if (b_re) begin
			b_rd_q <= b_mem[b_ra];
		end
	end

	// Sequencer: loads, clear and a next request after the walk has finished in the idle state, the merge walk elsewhere.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			a_cnt_q      <= '0;
			b_cnt_q      <= '0;
			rgs_q        <= '0;
			cgs_q        <= '0;
			exh_q        <= 1'b0;
			done         <= 1'b0;
			found        <= 1'b0;
			finished     <= 1'b0;
			status       <= ST_OK;
			result_row   <= '0;
			result_col   <= '0;
			result_value <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						found        <= 1'b0;
						finished     <= 1'b0;
						status       <= ST_OK;
						result_row   <= '0;
						result_col   <= '0;
						result_value <= '0;
						case (act)
							ACT_LOAD_A: begin
								done <= 1'b1;
								if (a_full) begin
									status <= ST_FULL;
								end else if (!a_order_ok) begin
									status <= ST_ORDER;
								end else begin
									a_cnt_q      <= a_cnt_q + 1'b1;
									a_last_row_q <= entry_row;
									a_last_col_q <= entry_col;
									exh_q        <= 1'b0;
								end
							end
							ACT_LOAD_B: begin
								done <= 1'b1;
								if (b_full) begin
									status <= ST_FULL;
								end else if (!b_order_ok) begin
									status <= ST_ORDER;
								end else begin
									b_cnt_q      <= b_cnt_q + 1'b1;
									b_last_row_q <= entry_row;
									b_last_col_q <= entry_col;
									exh_q        <= 1'b0;
								end
							end
							ACT_NEXT: begin
								if (exh_q) begin
									done     <= 1'b1;
									finished <= 1'b1;
								end else begin
									state_q <= S_PAIR;
								end
							end
							default: begin
								done    <= 1'b1;
								a_cnt_q <= '0;
								b_cnt_q <= '0;
								rgs_q   <= '0;
								cgs_q   <= '0;
								exh_q   <= 1'b0;
							end
						endcase
					end
				end
				S_PAIR: begin
					i_q   <= rgs_q;
					j_q   <= cgs_q;
					sum_q <= '0;
					if (rgs_q >= a_cnt_q) begin
						exh_q    <= 1'b1;
						done     <= 1'b1;
						finished <= 1'b1;
						state_q  <= S_IDLE;
					end else if (cgs_q >= b_cnt_q) begin
						state_q <= S_SKIP0;
					end else begin
						state_q <= S_HEAD;
					end
				end
				// The B walk for this row is done: step past the row's A entries.
				S_SKIP0: begin
					row0_q  <= a_rd_q.row;
					i_q     <= rgs_q + 1'b1;
					state_q <= S_SKIPRD;
				end
				S_SKIPRD: begin
					if (i_q >= a_cnt_q) begin
						rgs_q   <= i_q;
						cgs_q   <= '0;
						state_q <= S_PAIR;
					end else begin
						state_q <= S_SKIPEV;
					end
				end
				S_SKIPEV: begin
					if (a_rd_q.row == row0_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SKIPRD;
					end else begin
						rgs_q   <= i_q;
						cgs_q   <= '0;
						state_q <= S_PAIR;
					end
				end
				S_HEAD: begin
					row0_q  <= a_rd_q.row;
					col0_q  <= b_rd_q.col;
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (a_rd_q.col == b_rd_q.row) begin
						prod_q  <= a_rd_q.val * b_rd_q.val;
						state_q <= S_QUO;
					end else if (a_rd_q.col < b_rd_q.row) begin
						i_q     <= i_q + 1'b1;
						fa_q    <= 1'b1;
						fb_q    <= 1'b0;
						state_q <= S_FETCH;
					end else begin
						j_q     <= j_q + 1'b1;
						fa_q    <= 1'b0;
						fb_q    <= 1'b1;
						state_q <= S_FETCH;
					end
				end
				S_QUO: begin
					quo_q   <= quo_full[2*VAL_W+1:VAL_W+1];
					state_q <= S_REM;
				end
				S_REM: begin
					rem_q   <= rem_t;
					state_q <= S_FIX;
				end
				S_FIX: begin
					r_q     <= fix_n[VAL_W-1:0];
					state_q <= S_ACC;
				end
				S_ACC: begin
					sum_q   <= acc_n[VAL_W-1:0];
					i_q     <= i_q + 1'b1;
					j_q     <= j_q + 1'b1;
					fa_q    <= 1'b1;
					fb_q    <= 1'b1;
					state_q <= S_FETCH;
				end
				S_FETCH: state_q <= S_CHK;
				S_CHK: begin
					if (a_ok && b_ok) begin
						state_q <= S_CMP;
					end else if (b_ok) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_BRD;
					end else begin
						state_q <= S_END;
					end
				end
				// Finish the B column so the cursor lands on the next one.
				S_BRD: begin
					if (j_q >= b_cnt_q) begin
						state_q <= S_END;
					end else begin
						state_q <= S_BEV;
					end
				end
				S_BEV: begin
					if (b_rd_q.col == col0_q) begin
						j_q     <= j_q + 1'b1;
						state_q <= S_BRD;
					end else begin
						state_q <= S_END;
					end
				end
				S_END: begin
					cgs_q <= j_q;
					if (sum_q != '0) begin
						done         <= 1'b1;
						found        <= 1'b1;
						result_row   <= row0_q;
						result_col   <= col0_q;
						result_value <= sum_q;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_PAIR;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
